[sv/sbfi_pkg.sv]
// Shared types, constants and helpers for the strip band finder.
// No dependencies; every other file imports this package.
package sbfi_pkg;

  localparam int PROFILE_LEN = 1024;
  localparam int NUM_BANDS = 12;
  localparam int ADDR_W = $clog2(PROFILE_LEN);
  localparam int CNT_W = ADDR_W + 1;
  localparam int POS_W = 14;
  localparam int BAND_W = 4;
  localparam int BIDX_W = $clog2(NUM_BANDS);
  localparam int CUR_W = $clog2(NUM_BANDS + 1);
  localparam int ACC_W = 20;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  // (x + 1) * 13107 >> 16 equals x / 5 for the edge sums seen here
  localparam int DIV5_MUL = 13107;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_MARGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_ODD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_EVEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_Q16   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_FLOOR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT = 3'd7;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [9:0]  scan_start;
    logic [7:0]  drop_margin;
    logic [5:0]  half_window;
    logic [6:0]  pitch_odd;
    logic [6:0]  pitch_even;
    logic [15:0] ratio_q16;
    logic [15:0] area_floor;
    logic [9:0]  right_limit;
  } cfg_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [9:0]        location;
    logic [15:0]       area;
    logic              last_band;
  } res_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_REF_RD, ST_REF_WT, ST_SCAN_RD, ST_SCAN_WT,
    ST_THR_A, ST_THR_B, ST_THR_C, ST_CHECK, ST_AREA_INIT,
    ST_BAND, ST_EDGE, ST_DIV, ST_BASE, ST_SUM, ST_FIN, ST_EMIT
  } state_t;

  // window shift that leads into band k
  function automatic pos_t band_pitch(input logic [CUR_W-1:0] k, input cfg_t c);
    return k[0] ? pos_t'(c.pitch_odd) : pos_t'(c.pitch_even);
  endfunction

endpackage

[sv/sbfi_store.sv]
// Profile memory: one write port for loading, one registered read port.
// Reads outside the stored profile return zero. Depends on sbfi_pkg.
module sbfi_store (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [7:0]           wr_data,
  input  logic                 clr,
  input  sbfi_pkg::pos_t       rd_addr,
  output logic [7:0]           rd_data
);
  import sbfi_pkg::*;

  logic [7:0]       mem [PROFILE_LEN];
  logic [CNT_W-1:0] count;
  logic [7:0]       q;
  logic             in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clr) begin
      count <= '0;
    end else if (wr_en && count < CNT_W'(PROFILE_LEN)) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && count < CNT_W'(PROFILE_LEN)) begin
      mem[count[ADDR_W-1:0]] <= wr_data;
    end
    q <= mem[rd_addr[ADDR_W-1:0]];
    in_range <= (rd_addr >= pos_t'(0)) && (rd_addr < pos_t'(count));
  end

  assign rd_data = in_range ? q : 8'd0;

endmodule

[sv/sbfi_ctrl.sv]
// Sequencer: load, band scan, threshold set-up, edge baseline and area sum.
// Depends on sbfi_pkg; drives the sbfi_store ports.
module sbfi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  sbfi_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     sample,
  input  logic           last_sample,
  output logic           wr_en,
  output logic [7:0]     wr_data,
  output logic           clr,
  output sbfi_pkg::pos_t rd_addr,
  input  logic [7:0]     rd_data,
  output logic           res_valid,
  input  logic           res_ready,
  output sbfi_pkg::res_t res
);
  import sbfi_pkg::*;

  state_t state, state_next;

  logic signed [9:0] ref_lim;
  pos_t              i, ws0, we0, ws_cur, we_cur, wsj, wej;
  pos_t              wsb, web, l, r, sj;
  logic [CUR_W-1:0]  cursor, j, b;
  logic              first;
  logic [NUM_BANDS-1:0] found;
  logic [9:0]        loc [NUM_BANDS];
  logic [7:0]        thr [NUM_BANDS];
  logic [7:0]        v, ta, lq, rq, base;
  logic [3:0]        ek, ptag;
  logic              pv;
  logic [10:0]       lsum, rsum;
  logic [ACC_W-1:0]  acc;
  logic [15:0]       res_area;

  pos_t stop, rlim, i4;
  logic hit, drop, sum_more;
  logic [25:0] lmul, rmul;
  logic [8:0]  mean_sum;
  logic [23:0] bmul;

  assign stop = pos_t'(cfg.right_limit) + pos_t'(10);
  assign rlim = pos_t'(cfg.right_limit);
  assign i4 = i + pos_t'(4);
  assign drop = $signed({2'b00, rd_data}) < ref_lim;
  assign hit = first && (v < thr[cursor[BIDX_W-1:0]]) && (i >= ws_cur);
  assign sum_more = sj <= r;
  assign lmul = 26'(({1'b0, lsum} + 12'd1) * 14'(DIV5_MUL));
  assign rmul = 26'(({1'b0, rsum} + 12'd1) * 14'(DIV5_MUL));
  assign mean_sum = {1'b0, lq} + {1'b0, rq};
  assign bmul = mean_sum[8:1] * cfg.ratio_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    wr_en = 1'b0;
    wr_data = sample;
    clr = 1'b0;
    rd_addr = i;
    res_valid = 1'b0;
    res.band = BAND_W'(b);
    res.location = found[b[BIDX_W-1:0]] ? loc[b[BIDX_W-1:0]] : 10'd0;
    res.area = found[b[BIDX_W-1:0]] ? res_area : 16'd0;
    res.last_band = (b == CUR_W'(NUM_BANDS - 1));
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        wr_en = in_valid;
        if (in_valid && last_sample) state_next = ST_REF_RD;
      end
      ST_REF_RD: begin
        rd_addr = pos_t'(cfg.scan_start);
        state_next = ST_REF_WT;
      end
      ST_REF_WT: state_next = ST_SCAN_RD;
      ST_SCAN_RD: begin
        if (i > stop || cursor > CUR_W'(NUM_BANDS - 1)) begin
          state_next = ST_AREA_INIT;
        end else begin
          state_next = ST_SCAN_WT;
        end
      end
      ST_SCAN_WT: state_next = (!first && drop) ? ST_THR_A : ST_CHECK;
      ST_THR_A: begin
        rd_addr = wsj;
        state_next = ST_THR_B;
      end
      ST_THR_B: begin
        rd_addr = wej;
        state_next = ST_THR_C;
      end
      ST_THR_C: state_next = (j == CUR_W'(NUM_BANDS - 1)) ? ST_CHECK : ST_THR_A;
      ST_CHECK: state_next = (hit && i > rlim) ? ST_AREA_INIT : ST_SCAN_RD;
      ST_AREA_INIT: state_next = ST_BAND;
      ST_BAND: state_next = found[b[BIDX_W-1:0]] ? ST_EDGE : ST_EMIT;
      ST_EDGE: begin
        rd_addr = (ek < 4'd5) ? l + pos_t'(ek) - pos_t'(2) : r + pos_t'(ek) - pos_t'(7);
        if (ek == 4'd10 && !pv) state_next = ST_DIV;
      end
      ST_DIV: state_next = ST_BASE;
      ST_BASE: state_next = ST_SUM;
      ST_SUM: begin
        rd_addr = sj;
        if (!sum_more && !pv) state_next = ST_FIN;
      end
      ST_FIN: state_next = ST_EMIT;
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (b == CUR_W'(NUM_BANDS - 1)) begin
            clr = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_BAND;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
      found <= '0;
      cursor <= CUR_W'(1);
      b <= '0;
      j <= '0;
      pv <= 1'b0;
      ek <= '0;
    end else begin
      case (state)
        ST_REF_RD: begin
          i <= pos_t'(cfg.scan_start);
          cursor <= CUR_W'(1);
          first <= 1'b0;
          found <= '0;
        end
        ST_REF_WT: ref_lim <= $signed({2'b00, rd_data}) - $signed({2'b00, cfg.drop_margin});
        ST_SCAN_WT: begin
          v <= rd_data;
          if (!first && drop) begin
            loc[0] <= i4[9:0];
            found[0] <= 1'b1;
            ws0 <= i4 - pos_t'(cfg.half_window);
            we0 <= i4 + pos_t'(cfg.half_window);
            wsj <= i4 - pos_t'(cfg.half_window);
            wej <= i4 + pos_t'(cfg.half_window);
            j <= '0;
          end
        end
        ST_THR_B: ta <= rd_data;
        ST_THR_C: begin
          thr[j[BIDX_W-1:0]] <= (ta > rd_data) ? ta : rd_data;
          if (j == CUR_W'(NUM_BANDS - 1)) begin
            first <= 1'b1;
            ws_cur <= ws0 + band_pitch(CUR_W'(1), cfg);
            we_cur <= we0 + band_pitch(CUR_W'(1), cfg);
          end else begin
            j <= j + 1'b1;
            wsj <= wsj + band_pitch(j + 1'b1, cfg);
            wej <= wej + band_pitch(j + 1'b1, cfg);
          end
        end
        ST_CHECK: begin
          if (hit) begin
            if (i <= rlim) begin
              loc[cursor[BIDX_W-1:0]] <= i4[9:0];
              found[cursor[BIDX_W-1:0]] <= 1'b1;
              i <= we_cur + pos_t'(1);
              cursor <= cursor + 1'b1;
              ws_cur <= ws_cur + band_pitch(cursor + 1'b1, cfg);
              we_cur <= we_cur + band_pitch(cursor + 1'b1, cfg);
            end
          end else begin
            i <= i + pos_t'(1);
          end
        end
        ST_AREA_INIT: begin
          b <= '0;
          wsb <= ws0;
          web <= we0;
        end
        ST_BAND: begin
          l <= wsb;
          r <= (web >= rlim) ? rlim + pos_t'(5) : web;
          ek <= '0;
          pv <= 1'b0;
          lsum <= '0;
          rsum <= '0;
        end
        ST_EDGE: begin
          if (ek < 4'd10) begin
            ek <= ek + 1'b1;
            ptag <= ek;
            pv <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (ptag < 4'd5) lsum <= lsum + 11'(rd_data);
            else rsum <= rsum + 11'(rd_data);
          end
        end
        ST_DIV: begin
          lq <= lmul[23:16];
          rq <= rmul[23:16];
        end
        ST_BASE: begin
          base <= bmul[23:16];
          sj <= l;
          acc <= '0;
          pv <= 1'b0;
        end
        ST_SUM: begin
          if (sum_more) sj <= sj + pos_t'(1);
          pv <= sum_more;
          if (pv && rd_data < base) acc <= acc + ACC_W'(base - rd_data);
        end
        ST_FIN: begin
          if (acc < ACC_W'(cfg.area_floor)) res_area <= 16'd0;
          else if (acc > ACC_W'(16'hFFFF)) res_area <= 16'hFFFF;
          else res_area <= acc[15:0];
        end
        ST_EMIT: begin
          if (res_ready && b != CUR_W'(NUM_BANDS - 1)) begin
            b <= b + 1'b1;
            wsb <= wsb + band_pitch(b + 1'b1, cfg);
            web <= web + band_pitch(b + 1'b1, cfg);
          end
        end
        default: ;
      endcase
    end
  end

  a_scan_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN_WT |-> $past(state) == ST_SCAN_RD)
    else $error("scan compare without a scan read");
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    cursor <= CUR_W'(NUM_BANDS))
    else $error("band cursor overran");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && $past(state) == ST_EMIT) |-> $past(b) == CUR_W'(NUM_BANDS - 1))
    else $error("profile closed before all bands were sent");
  a_edge_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !pv)
    else $error("edge read still in flight");

endmodule

[sv/strip_band_find_and_integrate_core.sv]
// Top level: configuration registers, output register, store and sequencer.
// Depends on sbfi_pkg, sbfi_store and sbfi_ctrl.
//
//  channel | ports                                      | dir
//  in      | in_valid, in_stall, sample, last_sample    | beat in
//  out     | out_valid, out_stall, band, location, area,| beat out
//          | last_band                                  |
//  cfg     | cfg_we, cfg_index, cfg_data                | write only
//
// Loading accepts one sample per cycle. After the last sample the scan reads each
// profile position in turn, with threshold reads for every band at the first
// drop; each found band then reads its edge samples and its window samples, all
// bound by the single read port of the profile memory. Reset (rst, synchronous)
// restores the register defaults and empties the profile. out_stall holds the
// output beat; a full output register stalls the sequencer, and in_stall is high
// while a profile is being processed.
module strip_band_find_and_integrate_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    sample,
  input  logic                          last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbfi_pkg::BAND_W-1:0]   band,
  output logic [9:0]                    location,
  output logic [15:0]                   area,
  output logic                          last_band,
  input  logic                          cfg_we,
  input  logic [sbfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbfi_pkg::CFG_W-1:0]    cfg_data
);
  import sbfi_pkg::*;

  cfg_t cfg;
  res_t res, res_q;
  pos_t rd_addr;
  logic [7:0] rd_data, wr_data;
  logic wr_en, clr, res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_start  <= 10'd140;
      cfg.drop_margin <= 8'd4;
      cfg.half_window <= 6'd15;
      cfg.pitch_odd   <= 7'd38;
      cfg.pitch_even  <= 7'd37;
      cfg.ratio_q16   <= 16'd64882;
      cfg.area_floor  <= 16'd10;
      cfg.right_limit <= 10'd590;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_START:  cfg.scan_start  <= cfg_data[9:0];
        REG_DROP_MARGIN: cfg.drop_margin <= cfg_data[7:0];
        REG_HALF_WINDOW: cfg.half_window <= cfg_data[5:0];
        REG_PITCH_ODD:   cfg.pitch_odd   <= cfg_data[6:0];
        REG_PITCH_EVEN:  cfg.pitch_even  <= cfg_data[6:0];
        REG_RATIO_Q16:   cfg.ratio_q16   <= cfg_data[15:0];
        REG_AREA_FLOOR:  cfg.area_floor  <= cfg_data[15:0];
        REG_RIGHT_LIMIT: cfg.right_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // output register: take a new beat whenever the slot is free or draining
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) res_q <= res;
  end

  assign band = res_q.band;
  assign location = res_q.location;
  assign area = res_q.area;
  assign last_band = res_q.last_band;

  sbfi_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .clr     (clr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbfi_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .wr_en       (wr_en),
    .wr_data     (wr_data),
    .clr         (clr),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

endmodule
